// File: design/ktl_pkg.sv
`default_nettype none

package ktl_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int FUNC_W = 3;
    localparam int SEG_W  = 15;
    localparam int SIDE_W = 3;
    localparam int IDX_W  = 5;
    localparam int OUT_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL_IDX = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL_KEY = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEL_SEG = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_RENAME  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd6;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_DEL_IDX,
        OP_DEL_KEY,
        OP_DEL_SEG,
        OP_FIND,
        OP_RENAME,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SEG_W-1:0]  seg;
        logic [SIDE_W-1:0] side;
        logic              idx_last;
        logic [IDX_W-2:0]  idx;
        logic [SEG_W-1:0]  new_seg;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DONE
    } bk_state_t;

endpackage

`default_nettype wire

// File: design/kt_front.sv
`default_nettype none

module kt_front (
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire logic [ktl_pkg::FUNC_W-1:0] func,
    input  wire logic [ktl_pkg::SEG_W-1:0]  segment,
    input  wire logic [ktl_pkg::SIDE_W-1:0] side,
    input  wire logic [ktl_pkg::IDX_W-1:0]  index,
    input  wire logic [ktl_pkg::SEG_W-1:0]  new_segment,
    input  wire logic                       q_full,
    output logic                            q_push,
    output ktl_pkg::cmd_t                   q_cmd
);
    import ktl_pkg::*;

    op_t op;

    always_comb
    begin
        case (func)
            FUNC_ADD:     op = OP_ADD;
            FUNC_DEL_IDX: op = OP_DEL_IDX;
            FUNC_DEL_KEY: op = OP_DEL_KEY;
            FUNC_DEL_SEG: op = OP_DEL_SEG;
            FUNC_FIND:    op = OP_FIND;
            FUNC_RENAME:  op = OP_RENAME;
            FUNC_CLEAR:   op = OP_CLEAR;
            default:      op = OP_NOP;
        endcase
    end

    // any negative index selects the last entry
    always_comb
    begin
        q_cmd.op       = op;
        q_cmd.seg      = segment;
        q_cmd.side     = side;
        q_cmd.idx_last = index[IDX_W-1];
        q_cmd.idx      = index[IDX_W-2:0];
        q_cmd.new_seg  = new_segment;
    end

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

// File: design/kt_queue.sv
`default_nettype none

module kt_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ktl_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output ktl_pkg::cmd_t      head_cmd,
    output logic               empty
);
    import ktl_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign full     = (fill_reg == NW'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/kt_back.sv
`default_nettype none

module kt_back #(
    parameter int CAPACITY = ktl_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_empty,
    input  wire ktl_pkg::cmd_t             q_cmd,
    output logic                           q_pop,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output logic [ktl_pkg::OUT_W-1:0]      count,
    output logic [ktl_pkg::OUT_W-1:0]      position,
    output logic                           hit
);
    import ktl_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [SEG_W-1:0]  seg_reg  [CAPACITY];
    logic [SIDE_W-1:0] side_reg [CAPACITY];

    bk_state_t         state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    cmd_t              cmd_reg;
    logic [IW-1:0]     ptr_reg, ptr_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic              found_reg, found_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [OUT_W-1:0]  rsp_count_reg, rsp_position_reg;
    logic              rsp_hit_reg;

    logic [CAPACITY-1:0] match;
    logic              at_last;
    logic              exec_done;
    logic              load_cmd;
    logic              rsp_load;
    logic              rm_en;
    logic [IW-1:0]     rm_pos;
    logic              wr_seg_en, wr_side_en;
    logic [IW-1:0]     wr_idx;
    logic [SEG_W-1:0]  wr_seg;

    // per-entry key compare, side ignored for segment-wide operations
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            match[k] = (CW'(k) < count_reg) && (seg_reg[k] == cmd_reg.seg) &&
                       (cmd_reg.op == OP_DEL_SEG || cmd_reg.op == OP_RENAME ||
                        side_reg[k] == cmd_reg.side);
        end
    end

    assign at_last = (ptr_reg == IW'(count_reg - CW'(1)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        int del_i;
        logic del_ok;

        del_i      = cmd_reg.idx_last ? int'(count_reg) - 1 : int'(cmd_reg.idx);
        del_ok     = (count_reg != '0) && (del_i < int'(count_reg));

        q_pop      = 1'b0;
        load_cmd   = 1'b0;
        exec_done  = 1'b0;
        rsp_load   = 1'b0;
        rm_en      = 1'b0;
        rm_pos     = ptr_reg;
        wr_seg_en  = 1'b0;
        wr_side_en = 1'b0;
        wr_idx     = ptr_reg;
        wr_seg     = cmd_reg.seg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        found_next = found_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    load_cmd   = 1'b1;
                    found_next = 1'b0;
                    ptr_next   = (q_cmd.op == OP_DEL_SEG) ?
                                 IW'(count_reg - CW'(1)) : '0;
                end
            end
            BK_EXEC:
            begin
                case (cmd_reg.op)
                    OP_ADD:
                    begin
                        exec_done = 1'b1;
                        if (count_reg < CW'(CAPACITY))
                        begin
                            wr_seg_en  = 1'b1;
                            wr_side_en = 1'b1;
                            wr_idx     = IW'(count_reg);
                            pos_next   = IW'(count_reg);
                            found_next = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_DEL_IDX:
                    begin
                        exec_done = 1'b1;
                        if (del_ok)
                        begin
                            rm_en      = 1'b1;
                            rm_pos     = IW'(del_i);
                            pos_next   = IW'(del_i);
                            found_next = 1'b1;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    OP_DEL_KEY, OP_FIND:
                    begin
                        if (count_reg == '0)
                        begin
                            exec_done = 1'b1;
                        end
                        else if (match[ptr_reg])
                        begin
                            exec_done  = 1'b1;
                            pos_next   = ptr_reg;
                            found_next = 1'b1;
                            if (cmd_reg.op == OP_DEL_KEY)
                            begin
                                rm_en      = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        else if (at_last)
                        begin
                            exec_done = 1'b1;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + IW'(1);
                        end
                    end
                    OP_RENAME:
                    begin
                        if (count_reg == '0)
                        begin
                            exec_done = 1'b1;
                        end
                        else
                        begin
                            if (match[ptr_reg])
                            begin
                                wr_seg_en  = 1'b1;
                                wr_seg     = cmd_reg.new_seg;
                                found_next = 1'b1;
                                if (!found_reg)
                                begin
                                    pos_next = ptr_reg;
                                end
                            end
                            if (at_last)
                            begin
                                exec_done = 1'b1;
                            end
                            else
                            begin
                                ptr_next = ptr_reg + IW'(1);
                            end
                        end
                    end
                    OP_DEL_SEG:
                    begin
                        // downward scan, so a removal never moves an entry still to visit
                        if (count_reg == '0)
                        begin
                            exec_done = 1'b1;
                        end
                        else
                        begin
                            if (match[ptr_reg])
                            begin
                                rm_en      = 1'b1;
                                count_next = count_reg - CW'(1);
                                found_next = 1'b1;
                                if (!found_reg)
                                begin
                                    pos_next = ptr_reg;
                                end
                            end
                            if (ptr_reg == '0)
                            begin
                                exec_done = 1'b1;
                            end
                            else
                            begin
                                ptr_next = ptr_reg - IW'(1);
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        exec_done  = 1'b1;
                        count_next = '0;
                    end
                    default:
                    begin
                        exec_done = 1'b1;
                    end
                endcase
            end
            BK_DONE:
            begin
                rsp_load = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cmd)
        begin
            cmd_reg <= q_cmd;
        end
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        if (rsp_load)
        begin
            rsp_count_reg    <= OUT_W'(count_reg);
            rsp_position_reg <= found_reg ? OUT_W'(pos_reg) : '1;
            rsp_hit_reg      <= found_reg;
        end
    end

    // compaction: every entry at or above the removed one, save the top slot, takes its upper neighbor
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY - 1; k++)
        begin
            if (rm_en && (IW'(k) >= rm_pos))
            begin
                seg_reg[k]  <= seg_reg[k + 1];
                side_reg[k] <= side_reg[k + 1];
            end
        end
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (wr_seg_en && (wr_idx == IW'(k)))
            begin
                seg_reg[k] <= wr_seg;
            end
            if (wr_side_en && (wr_idx == IW'(k)))
            begin
                side_reg[k] <= cmd_reg.side;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign count     = rsp_count_reg;
    assign position  = rsp_position_reg;
    assign hit       = rsp_hit_reg;

endmodule

`default_nettype wire

// File: design/keyed_target_list.sv
// path: an accepted word waits in the queue, then the back end moves idle, exec, done
//   and loads the result register; add, delete at index and clear need no scan, while
//   find, delete key, rename and delete segment scan in exec, the back end checking one
//   entry per cycle; a scan of an empty list ends without visiting any entry
// flow: the back end works one word at a time; a two-word queue lets the front keep accepting
// reset: asynchronous, clears the list to empty, the queue and the result valid flag
`default_nettype none

module keyed_target_list #(
    parameter int CAPACITY = ktl_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire logic [ktl_pkg::FUNC_W-1:0] func,
    input  wire logic [ktl_pkg::SEG_W-1:0]  segment,
    input  wire logic [ktl_pkg::SIDE_W-1:0] side,
    input  wire logic [ktl_pkg::IDX_W-1:0]  index,
    input  wire logic [ktl_pkg::SEG_W-1:0]  new_segment,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output logic [ktl_pkg::OUT_W-1:0]       count,
    output logic [ktl_pkg::OUT_W-1:0]       position,
    output logic                            hit
);
    import ktl_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_push, q_full, q_pop, q_empty;

    kt_front u_front (
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .segment     (segment),
        .side        (side),
        .index       (index),
        .new_segment (new_segment),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (front_cmd)
    );

    kt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    kt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .count     (count),
        .position  (position),
        .hit       (hit)
    );

endmodule

`default_nettype wire

// File: design/kt_checker.sv
`default_nettype none

module kt_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [ktl_pkg::OUT_W-1:0] count,
    input wire logic [ktl_pkg::OUT_W-1:0] position,
    input wire logic                      hit
);
    import ktl_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(count) &&
                                    $stable(position) && $stable(hit))
    else $error("result word changed while stalled");

    // a miss always reports no position
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> position == {OUT_W{1'b1}})
    else $error("miss with a position");

    // no result word while in reset
    assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
    else $error("result word during reset");

endmodule

bind keyed_target_list kt_checker u_kt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .count     (count),
    .position  (position),
    .hit       (hit)
);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ktl_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEFAULT;
    localparam int N_RANDOM    = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 500;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [SEG_W-1:0]  seg;
        logic [SIDE_W-1:0] side;
        logic [IDX_W-1:0]  idx;
        logic [SEG_W-1:0]  new_seg;
    } list_word_t;

    typedef struct {
        logic [OUT_W-1:0] count;
        logic [OUT_W-1:0] position;
        logic             hit;
    } list_result_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              req_valid   = 1'b0;
    logic              req_ready;
    logic [FUNC_W-1:0] func        = '0;
    logic [SEG_W-1:0]  segment     = '0;
    logic [SIDE_W-1:0] side        = '0;
    logic [IDX_W-1:0]  index       = '0;
    logic [SEG_W-1:0]  new_segment = '0;
    logic              rsp_valid;
    logic              rsp_ready   = 1'b0;
    logic [OUT_W-1:0]  count;
    logic [OUT_W-1:0]  position;
    logic              hit;

    keyed_target_list #(
        .CAPACITY(LIST_CAP)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .func       (func),
        .segment    (segment),
        .side       (side),
        .index      (index),
        .new_segment(new_segment),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .count      (count),
        .position   (position),
        .hit        (hit)
    );

    // predicted list contents
    logic [15:0]       list_seg [LIST_CAP];
    logic [SIDE_W-1:0] list_side[LIST_CAP];
    int                list_cnt;

    list_word_t   word_q[$];
    list_result_t result_q[$];
    list_word_t   cur_word;

    int  gap_cnt      = 0;
    int  wait_cnt     = 0;
    bit  tx_burst     = 1'b0;
    bit  rx_burst     = 1'b0;
    bit  rx_hold      = 1'b0;
    bit  hold_done    = 1'b0;
    int  hold_cnt     = 0;
    int  stall_cycles = 0;
    int  words_sent   = 0;
    int  results_seen = 0;
    int  hit_count    = 0;
    int  full_count   = 0;
    int  errors       = 0;

    function automatic void clear_list();
        for (int k = 0; k < LIST_CAP; k++)
        begin
            list_seg[k]  = 16'hFFFF;
            list_side[k] = '0;
        end
        list_cnt = 0;
    endfunction

    function automatic void drop_entry(int k);
        for (int j = k; j + 1 < list_cnt; j++)
        begin
            list_seg[j]  = list_seg[j+1];
            list_side[j] = list_side[j+1];
        end
        list_cnt--;
        list_seg[list_cnt]  = 16'hFFFF;
        list_side[list_cnt] = '0;
    endfunction

    function automatic int locate_key(logic [SEG_W-1:0] s, logic [SIDE_W-1:0] sd);
        for (int j = 0; j < list_cnt; j++)
            if (list_seg[j] == {1'b0, s} && list_side[j] == sd)
                return j;
        return -1;
    endfunction

    function automatic list_result_t apply_list_op(list_word_t w);
        list_result_t r;
        int           pos;
        bit           h;
        int           i;
        pos = -1;
        h   = 1'b0;
        case (w.func)
            FUNC_ADD:
                if (list_cnt < LIST_CAP)
                begin
                    list_seg[list_cnt]  = {1'b0, w.seg};
                    list_side[list_cnt] = w.side;
                    pos = list_cnt;
                    list_cnt++;
                    h = 1'b1;
                end
            FUNC_DEL_IDX:
            begin
                i = w.idx[IDX_W-1] ? list_cnt - 1 : int'(w.idx[IDX_W-2:0]);
                if (list_cnt > 0 && i >= 0 && i < list_cnt)
                begin
                    drop_entry(i);
                    pos = i;
                    h   = 1'b1;
                end
            end
            FUNC_DEL_KEY:
            begin
                pos = locate_key(w.seg, w.side);
                if (pos >= 0)
                begin
                    drop_entry(pos);
                    h = 1'b1;
                end
            end
            FUNC_DEL_SEG:
                for (int j = list_cnt; j > 0; j--)
                    if (list_seg[j-1] == {1'b0, w.seg})
                    begin
                        drop_entry(j - 1);
                        if (pos < 0)
                            pos = j - 1;
                        h = 1'b1;
                    end
            FUNC_FIND:
            begin
                pos = locate_key(w.seg, w.side);
                h   = (pos >= 0);
            end
            FUNC_RENAME:
                for (int j = 0; j < list_cnt; j++)
                    if (list_seg[j] == {1'b0, w.seg})
                    begin
                        list_seg[j] = {1'b0, w.new_seg};
                        if (pos < 0)
                            pos = j;
                        h = 1'b1;
                    end
            FUNC_CLEAR:
                clear_list();
            default:
                ;
        endcase
        r.count    = OUT_W'(list_cnt);
        r.position = OUT_W'(pos);
        r.hit      = h;
        return r;
    endfunction

    function automatic logic [SEG_W-1:0] pick_seg();
        case ($urandom_range(0, 9))
            7:       return '1;
            8, 9:    return SEG_W'($urandom);
            default: return SEG_W'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [SIDE_W-1:0] pick_side();
        if ($urandom_range(0, 3) == 0)
            return SIDE_W'($urandom);
        return SIDE_W'($urandom_range(0, 1));
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 3))
            0:       return '1;
            1:       return {1'b1, 4'($urandom)};
            default: return IDX_W'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic push_word(logic [FUNC_W-1:0] f, logic [SEG_W-1:0] s,
                             logic [SIDE_W-1:0] sd, logic [IDX_W-1:0] ix,
                             logic [SEG_W-1:0] ns);
        list_word_t w;
        w.func    = f;
        w.seg     = s;
        w.side    = sd;
        w.idx     = ix;
        w.new_seg = ns;
        word_q.push_back(w);
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk)
    begin
        int           g;
        list_result_t r;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_cnt   <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                r = apply_list_op(cur_word);
                result_q.push_back(r);
                words_sent <= words_sent + 1;
                if (cur_word.func == FUNC_ADD && !r.hit)
                    full_count <= full_count + 1;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                g = (tx_burst || rx_hold) ? 0 : $urandom_range(0, 6);
                if (g == 0 && word_q.size() > 0)
                begin
                    cur_word = word_q.pop_front();
                    func        <= cur_word.func;
                    segment     <= cur_word.seg;
                    side        <= cur_word.side;
                    index       <= cur_word.idx;
                    new_segment <= cur_word.new_seg;
                end
                else
                begin
                    req_valid <= 1'b0;
                    gap_cnt   <= (g > 0) ? g - 1 : 0;
                end
            end
            else if (!req_valid)
            begin
                if (gap_cnt > 0)
                    gap_cnt <= gap_cnt - 1;
                else if (word_q.size() > 0)
                begin
                    cur_word = word_q.pop_front();
                    func        <= cur_word.func;
                    segment     <= cur_word.seg;
                    side        <= cur_word.side;
                    index       <= cur_word.idx;
                    new_segment <= cur_word.new_seg;
                    req_valid   <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        int           w;
        list_result_t e;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            wait_cnt  <= 0;
        end
        else
        begin
            w = wait_cnt;
            if (rsp_valid && rsp_ready)
            begin
                results_seen <= results_seen + 1;
                if (hit === 1'b1)
                    hit_count <= hit_count + 1;
                if (result_q.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t: expected no result, actual count %0d position %0d hit %0d",
                             $time, count, $signed(position), hit);
                end
                else
                begin
                    e = result_q.pop_front();
                    if (count !== e.count || position !== e.position || hit !== e.hit)
                    begin
                        errors <= errors + 1;
                        $display("%0t: expected count %0d position %0d hit %0d,",
                                 $time, e.count, $signed(e.position), e.hit,
                                 " actual count %0d position %0d hit %0d",
                                 count, $signed(position), hit);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                w = rx_burst ? 0 : $urandom_range(0, 6);
            end
            else if (w > 0)
                w = w - 1;
            wait_cnt  <= w;
            rsp_ready <= (w == 0) && !rx_hold;
        end
    end

    // long receiver hold-off so the input side backs up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_hold   <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt  <= 0;
        end
        else if (!rx_hold && !hold_done && words_sent >= HOLD_AFTER)
        begin
            rx_hold  <= 1'b1;
            hold_cnt <= 0;
        end
        else if (rx_hold)
        begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
            begin
                rx_hold   <= 1'b0;
                hold_done <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("keyed_target_list: mismatch");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int n;
        int r;
        clear_list();

        // directed words
        push_word(FUNC_CLEAR,   '0,      '0,   '0,     '0);
        push_word(FUNC_FIND,    '0,      '0,   '0,     '0);
        push_word(FUNC_DEL_IDX, '0,      '0,   '1,     '0);
        push_word(FUNC_DEL_KEY, '1,      '1,   '0,     '1);
        push_word(FUNC_DEL_SEG, '0,      '0,   '0,     '0);
        push_word(FUNC_RENAME,  '0,      '0,   '0,     15'd5);
        push_word(FUNC_ADD,     '1,      '1,   '0,     '0);
        push_word(FUNC_ADD,     '0,      '0,   '0,     '0);
        push_word(FUNC_ADD,     15'd1,   3'd3, '0,     '0);
        push_word(FUNC_ADD,     '1,      3'd2, '0,     '0);
        push_word(FUNC_FIND,    '1,      '1,   '0,     '0);
        push_word(FUNC_FIND,    15'd1,   3'd4, '0,     '0);
        push_word(FUNC_RENAME,  15'd1,   '0,   '0,     '1);
        push_word(FUNC_DEL_SEG, '1,      '0,   '0,     '0);
        push_word(FUNC_DEL_IDX, '0,      '0,   5'd15,  '0);
        push_word(FUNC_DEL_IDX, '0,      '0,   5'h10,  '0);
        push_word(FUNC_ADD,     15'd2,   3'd1, '0,     '0);
        push_word(FUNC_DEL_KEY, 15'd9,   3'd1, '0,     '0);
        push_word(FUNC_DEL_KEY, 15'd2,   3'd1, '0,     '0);
        push_word(3'd7,         '1,      '1,   '1,     '1);
        push_word(FUNC_DEL_IDX, '0,      '0,   5'd0,   '0);
        push_word(FUNC_CLEAR,   '1,      '1,   '1,     '1);

        // random words, with runs of adds that fill the list
        n = 0;
        while (n < N_RANDOM)
        begin
            r = (n == 0) ? 0 : $urandom_range(0, 99);
            if (r == 0)
            begin
                repeat (LIST_CAP + 1)
                    push_word(FUNC_ADD, pick_seg(), pick_side(), pick_index(), pick_seg());
                n += LIST_CAP + 1;
            end
            else
            begin
                if (r < 36)
                    push_word(FUNC_ADD, pick_seg(), pick_side(), pick_index(), pick_seg());
                else if (r < 48)
                    push_word(FUNC_DEL_IDX, pick_seg(), pick_side(), pick_index(), pick_seg());
                else if (r < 60)
                    push_word(FUNC_DEL_KEY, pick_seg(), pick_side(), pick_index(), pick_seg());
                else if (r < 66)
                    push_word(FUNC_DEL_SEG, pick_seg(), pick_side(), pick_index(), pick_seg());
                else if (r < 82)
                    push_word(FUNC_FIND, pick_seg(), pick_side(), pick_index(), pick_seg());
                else if (r < 94)
                    push_word(FUNC_RENAME, pick_seg(), pick_side(), pick_index(), pick_seg());
                else if (r < 97)
                    push_word(FUNC_CLEAR, pick_seg(), pick_side(), pick_index(), pick_seg());
                else
                    push_word(3'd7, pick_seg(), pick_side(), pick_index(), pick_seg());
                n++;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (word_q.size() > 0 || req_valid || result_q.size() > 0);
        repeat (LIST_CAP + 8) @(posedge clk);

        $display("covered %0d words and %0d results, %0d with hit set, %0d adds on a full list",
                 words_sent, results_seen, hit_count, full_count);
        if (errors == 0 && result_q.size() == 0)
            $display("keyed_target_list: match");
        else
            $display("keyed_target_list: mismatch");
        $finish;
    end

endmodule
